// File: src/message_slot_ring_byte_queue_macros.svh
// assertion macros for the message slot ring byte queue
`ifndef MESSAGE_SLOT_RING_BYTE_QUEUE_MACROS_SVH
`define MESSAGE_SLOT_RING_BYTE_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define MSRBQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MSRBQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MSRBQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MSRBQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/msrbq_pkg.sv
package msrbq_pkg;

  localparam int MAX_SLOTS_DEFAULT         = 16;
  localparam int MAX_MESSAGE_BYTES_DEFAULT = 64;
  localparam int CAPACITY_RESET            = 16;

  localparam int COMMAND_W  = 2;
  localparam int LENGTH_W   = 7;
  localparam int SLOT_W     = 4;
  localparam int OFFSET_W   = 6;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int CAPACITY_W = 5;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_RESERVE = 2'd0,
    CMD_FILL    = 2'd1,
    CMD_TAKE    = 2'd2
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic [LENGTH_W-1:0]  message_length;
    logic [SLOT_W-1:0]    target_slot;
    logic [OFFSET_W-1:0]  byte_offset;
    logic [BYTE_W-1:0]    fill_byte;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_of_message;
    logic [COUNT_W-1:0]  used_slots;
    logic [COUNT_W-1:0]  free_slots;
  } out_word_t;

endpackage

// File: src/msrbq_ram.sv
module msrbq_ram import msrbq_pkg::*; #(
  parameter int WIDTH = BYTE_W,
  parameter int DEPTH = MAX_SLOTS_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/msrbq_ctrl.sv
`include "message_slot_ring_byte_queue_macros.svh"

module msrbq_ctrl import msrbq_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT,
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEFAULT,
  localparam int SW = $clog2(MAX_SLOTS),
  localparam int CW = $clog2(MAX_SLOTS + 1),
  localparam int LW = $clog2(MAX_MESSAGE_BYTES + 1),
  localparam int DEPTH = MAX_SLOTS * MAX_MESSAGE_BYTES,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAPACITY_W-1:0] cfg_data,
  output logic                  len_re,
  output logic [SW-1:0]         len_raddr,
  input  logic [LW-1:0]         len_rdata,
  output logic                  len_we,
  output logic [SW-1:0]         len_waddr,
  output logic [LW-1:0]         len_wdata,
  output logic                  store_re,
  output logic [AW-1:0]         store_raddr,
  input  logic [BYTE_W-1:0]     store_rdata,
  output logic                  store_we,
  output logic [AW-1:0]         store_waddr,
  output logic [BYTE_W-1:0]     store_wdata
);

  localparam int SXW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int OXW = (LW > OFFSET_W) ? LW : OFFSET_W;
  localparam int LXW = (LW > LENGTH_W) ? LW : LENGTH_W;
  localparam int KXW = (CW > CAPACITY_W) ? CW : CAPACITY_W;
  localparam int RESET_CAP = (CAPACITY_RESET > MAX_SLOTS) ? MAX_SLOTS : CAPACITY_RESET;

  typedef enum logic {IDLE, EXEC} state_t;

  state_t              state;
  in_word_t            item;
  logic [SW-1:0]       head, tail;
  logic [LW-1:0]       taken;
  logic                ring_full;
  logic [MAX_SLOTS-1:0] reserved;
  logic [CW-1:0]       cap;

  logic [SW-1:0]       head_next, tail_next, head_inc, tail_inc, fill_slot;
  logic [LW-1:0]       taken_next, taken_inc;
  logic                ring_full_next;
  logic                res_set, res_clr, len_wr, store_wr;
  logic                accept, done;
  logic                len_bad, fill_ok, take_ok;
  logic [CW-1:0]       used_next, cap_next;
  logic [KXW-1:0]      cfg_ext;
  out_word_t           out_next;

  assign in_stall  = (state != IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign done      = (state == EXEC) && (!out_valid || !out_stall);

  // reads go out in the accept cycle, data is back for the execute cycle
  assign len_re      = accept;
  assign len_raddr   = (in_data.command == CMD_FILL) ? SW'(in_data.target_slot) : tail;
  assign store_re    = accept;
  assign store_raddr = AW'(tail) * AW'(MAX_MESSAGE_BYTES) + AW'(taken);

  assign fill_slot   = SW'(item.target_slot);
  assign len_we      = done && len_wr;
  assign len_waddr   = head;
  assign len_wdata   = LW'(item.message_length);
  assign store_we    = done && store_wr;
  assign store_waddr = AW'(fill_slot) * AW'(MAX_MESSAGE_BYTES) + AW'(item.byte_offset);
  assign store_wdata = item.fill_byte;

  assign head_inc  = ((CW'(head) + CW'(1)) == cap) ? '0 : head + SW'(1);
  assign tail_inc  = ((CW'(tail) + CW'(1)) == cap) ? '0 : tail + SW'(1);
  assign taken_inc = taken + LW'(1);

  assign len_bad = (item.message_length == '0) ||
                   (LXW'(item.message_length) > LXW'(MAX_MESSAGE_BYTES));
  assign fill_ok = (SXW'(item.target_slot) < SXW'(cap)) && reserved[fill_slot] &&
                   (OXW'(item.byte_offset) < OXW'(len_rdata));
  assign take_ok = (CW'(tail) < cap) && reserved[tail] && (taken < len_rdata);

  // clamp the written capacity into one to the slot count
  assign cfg_ext  = KXW'(cfg_data);
  assign cap_next = (cfg_ext == '0) ? CW'(1) :
                    (cfg_ext > KXW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cfg_ext);

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    taken_next     = taken;
    ring_full_next = ring_full;
    res_set        = 1'b0;
    res_clr        = 1'b0;
    len_wr         = 1'b0;
    store_wr       = 1'b0;
    out_next       = '0;
    out_next.status = STATUS_BAD;
    case (item.command)
      CMD_RESERVE: begin
        if (len_bad) begin
          out_next.status = STATUS_BAD;
        end else if (ring_full || (CW'(head) >= cap)) begin
          out_next.status = STATUS_FULL;
        end else begin
          res_set = 1'b1;
          len_wr  = 1'b1;
          out_next.granted_slot = SLOT_W'(head);
          if (head == tail) begin
            taken_next = '0;
          end
          head_next      = head_inc;
          ring_full_next = (head_inc == tail);
          out_next.status = STATUS_OK;
        end
      end
      CMD_FILL: begin
        if (fill_ok) begin
          store_wr = 1'b1;
          out_next.status = STATUS_OK;
        end
      end
      CMD_TAKE: begin
        if (!take_ok) begin
          out_next.status = STATUS_EMPTY;
        end else begin
          out_next.out_byte = store_rdata;
          taken_next = taken_inc;
          if (taken_inc >= len_rdata) begin
            res_clr        = 1'b1;
            taken_next     = '0;
            tail_next      = tail_inc;
            ring_full_next = 1'b0;
            out_next.last_of_message = 1'b1;
          end
          out_next.status = STATUS_OK;
        end
      end
      default: ;
    endcase

    if (ring_full_next) begin
      used_next = cap;
    end else if (head_next >= tail_next) begin
      used_next = CW'(head_next) - CW'(tail_next);
    end else begin
      used_next = cap + CW'(head_next) - CW'(tail_next);
    end
    out_next.used_slots = COUNT_W'(used_next);
    out_next.free_slots = COUNT_W'(cap - used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      taken     <= '0;
      ring_full <= 1'b0;
      reserved  <= '0;
      cap       <= CW'(RESET_CAP);
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap       <= cap_next;
        head      <= '0;
        tail      <= '0;
        taken     <= '0;
        ring_full <= 1'b0;
        reserved  <= '0;
      end else if (done) begin
        head      <= head_next;
        tail      <= tail_next;
        taken     <= taken_next;
        ring_full <= ring_full_next;
        if (res_set) begin
          reserved[head] <= 1'b1;
        end
        if (res_clr) begin
          reserved[tail] <= 1'b0;
        end
      end
      case (state)
        IDLE: begin
          if (accept) begin
            item  <= in_data;
            state <= EXEC;
          end
        end
        EXEC: begin
          if (done) begin
            out_data  <= out_next;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `MSRBQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, in_stall, "accepted word did not start execute")
  `MSRBQ_ASSERT_IMPL(a_full_pointers_meet, clk, rst, ring_full, head == tail, "ring full with head away from tail")
  `MSRBQ_ASSERT_IMPL(a_pointers_in_ring, clk, rst, 1'b1, (CW'(head) < cap) && (CW'(tail) < cap), "pointer beyond capacity")

endmodule

// File: src/message_slot_ring_byte_queue.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_data   (in_word_t)
// out      output     out_valid/ out_stall out_data  (out_word_t)
// cfg      input      cfg_valid/ cfg_ready cfg_data  (slot capacity)
//
// each command is accepted and then executed: the accept cycle reads the slot length and
// byte memories, the execute state checks, writes back and loads the result
// register; the next word is taken once the result register has been loaded
// a stalled result holds the block in execute until it is taken
// reset clears the reserved bits and pointers at once; the byte memory keeps
// whatever it holds and needs no clearing pass
module message_slot_ring_byte_queue import msrbq_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT,
  parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAPACITY_W-1:0] cfg_data
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int LW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int DEPTH = MAX_SLOTS * MAX_MESSAGE_BYTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              len_re, len_we;
  logic [SW-1:0]     len_raddr, len_waddr;
  logic [LW-1:0]     len_rdata, len_wdata;
  logic              store_re, store_we;
  logic [AW-1:0]     store_raddr, store_waddr;
  logic [BYTE_W-1:0] store_rdata, store_wdata;

  msrbq_ctrl #(
    .MAX_SLOTS(MAX_SLOTS),
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .len_re(len_re),
    .len_raddr(len_raddr),
    .len_rdata(len_rdata),
    .len_we(len_we),
    .len_waddr(len_waddr),
    .len_wdata(len_wdata),
    .store_re(store_re),
    .store_raddr(store_raddr),
    .store_rdata(store_rdata),
    .store_we(store_we),
    .store_waddr(store_waddr),
    .store_wdata(store_wdata)
  );

  // slot lengths, only meaningful where the reserved bit is set
  msrbq_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_SLOTS)
  ) u_len_ram (
    .clk(clk),
    .we(len_we),
    .waddr(len_waddr),
    .wdata(len_wdata),
    .re(len_re),
    .raddr(len_raddr),
    .rdata(len_rdata)
  );

  msrbq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store_ram (
    .clk(clk),
    .we(store_we),
    .waddr(store_waddr),
    .wdata(store_wdata),
    .re(store_re),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

endmodule

// File: tb/message_slot_ring_byte_queue_checker.sv
module message_slot_ring_byte_queue_checker import msrbq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CAPACITY_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    results_owed,
  output int                    results_checked
);

  localparam int SLOTS = MAX_SLOTS_DEFAULT;
  localparam int SLOT_BYTES = MAX_MESSAGE_BYTES_DEFAULT;

  logic [BYTE_W-1:0]     byte_store [SLOTS][SLOT_BYTES];
  logic [LENGTH_W-1:0]   slot_len [SLOTS];
  logic                  slot_busy [SLOTS];
  logic [LENGTH_W-1:0]   taken_count;
  logic [SLOT_W-1:0]     head_slot;
  logic [SLOT_W-1:0]     tail_slot;
  logic                  ring_full;
  logic [CAPACITY_W-1:0] capacity;

  out_word_t predicted_results [$];

  function automatic void empty_ring();
    for (int s = 0; s < SLOTS; s++) begin
      slot_len[s] = '0;
      slot_busy[s] = 1'b0;
    end
    taken_count = '0;
    head_slot = '0;
    tail_slot = '0;
    ring_full = 1'b0;
  endfunction

  function automatic void set_capacity(logic [CAPACITY_W-1:0] v);
    // out-of-range capacity is pinned to 1..SLOTS
    if (v == 0) capacity = CAPACITY_W'(1);
    else if (v > CAPACITY_W'(SLOTS)) capacity = CAPACITY_W'(SLOTS);
    else capacity = v;
    empty_ring();
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(logic [SLOT_W-1:0] s);
    return SLOT_W'((COUNT_W'(s) + COUNT_W'(1)) % capacity);
  endfunction

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    logic [COUNT_W-1:0] used;
    r = '0;
    r.status = STATUS_BAD;
    case (w.command)
      CMD_RESERVE: begin
        // the length check wins over the full check
        if (w.message_length == 0 || w.message_length > LENGTH_W'(SLOT_BYTES)) begin
          r.status = STATUS_BAD;
        end else if (ring_full || COUNT_W'(head_slot) >= capacity) begin
          r.status = STATUS_FULL;
        end else begin
          slot_busy[head_slot] = 1'b1;
          slot_len[head_slot] = w.message_length;
          r.granted_slot = head_slot;
          if (head_slot == tail_slot) taken_count = '0;
          head_slot = next_slot(head_slot);
          ring_full = (head_slot == tail_slot);
          r.status = STATUS_OK;
        end
      end
      CMD_FILL: begin
        if (COUNT_W'(w.target_slot) < capacity && slot_busy[w.target_slot] &&
            LENGTH_W'(w.byte_offset) < slot_len[w.target_slot]) begin
          byte_store[w.target_slot][w.byte_offset] = w.fill_byte;
          r.status = STATUS_OK;
        end
      end
      CMD_TAKE: begin
        if (COUNT_W'(tail_slot) >= capacity || !slot_busy[tail_slot] ||
            taken_count >= slot_len[tail_slot]) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.out_byte = byte_store[tail_slot][OFFSET_W'(taken_count)];
          taken_count = taken_count + LENGTH_W'(1);
          if (taken_count >= slot_len[tail_slot]) begin
            // last byte releases the tail slot
            slot_busy[tail_slot] = 1'b0;
            slot_len[tail_slot] = '0;
            taken_count = '0;
            tail_slot = next_slot(tail_slot);
            ring_full = 1'b0;
            r.last_of_message = 1'b1;
          end
          r.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    if (ring_full) used = capacity;
    else if (head_slot >= tail_slot) used = COUNT_W'(head_slot) - COUNT_W'(tail_slot);
    else used = capacity + COUNT_W'(head_slot) - COUNT_W'(tail_slot);
    r.used_slots = used;
    r.free_slots = capacity - used;
    return r;
  endfunction

  task automatic report_failure(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_failure($sformatf("word %0d %s got %0d expected %0d",
                               results_checked, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        for (int b = 0; b < SLOT_BYTES; b++) byte_store[s][b] = '0;
      end
      set_capacity(CAPACITY_W'(CAPACITY_RESET));
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          report_failure($sformatf("result word %h with nothing outstanding", out_data));
        end else begin
          want = predicted_results.pop_front();
          check_field("status", out_data.status, want.status);
          check_field("granted_slot", out_data.granted_slot, want.granted_slot);
          check_field("out_byte", out_data.out_byte, want.out_byte);
          check_field("last_of_message", out_data.last_of_message, want.last_of_message);
          check_field("used_slots", out_data.used_slots, want.used_slots);
          check_field("free_slots", out_data.free_slots, want.free_slots);
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) set_capacity(cfg_data);
      if (in_valid && !in_stall) predicted_results.push_back(apply_command(in_data));
    end
    results_owed <= predicted_results.size();
  end

endmodule

// File: tb/tb_message_slot_ring_byte_queue.sv
module tb_message_slot_ring_byte_queue;
  import msrbq_pkg::*;

  localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int WORDS_PER_PHASE = 88;
  localparam int PREFILL_BYTES = 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CAPACITY_W-1:0] cfg_data;

  int mismatch_count;
  int results_owed;
  int results_checked;
  int words_sent = 0;
  int settings_done = 0;
  int idle_cycles = 0;
  bit steady_flow = 1'b0;

  always #5 clk = ~clk;

  message_slot_ring_byte_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  message_slot_ring_byte_queue_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("[message_slot_ring_byte_queue] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver backpressure in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!steady_flow && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_word_t make_word(logic [COMMAND_W-1:0] cmd, int len, int slot,
                                         int off, int val);
    in_word_t w;
    w.command = cmd;
    w.message_length = LENGTH_W'(len);
    w.target_slot = SLOT_W'(slot);
    w.byte_offset = OFFSET_W'(off);
    w.fill_byte = BYTE_W'(val);
    return w;
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input in_word_t w);
    if (!steady_flow && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAPACITY_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  initial begin
    in_word_t w;
    int pick;
    int cap_now;
    logic [CAPACITY_W-1:0] plan [$];

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // claim every slot and write its leading bytes once; random reserves stay
    // within them so no take can ever land on a byte that was never written
    for (int s = 0; s < MAX_SLOTS_DEFAULT; s++) begin
      send_word(make_word(CMD_RESERVE, MAX_MESSAGE_BYTES_DEFAULT, 0, 0, 0));
    end
    for (int s = 0; s < MAX_SLOTS_DEFAULT; s++) begin
      for (int b = 0; b < PREFILL_BYTES; b++) begin
        send_word(make_word(CMD_FILL, $urandom_range(0, 127), s, b, $urandom_range(0, 255)));
      end
    end
    send_word(make_word(CMD_RESERVE, 1, 0, 0, 0));

    // two-slot ring walked through its corner cases
    write_capacity(CAPACITY_W'(2));
    send_word(make_word(CMD_TAKE, 0, 0, 0, 0));
    send_word(make_word(CMD_RESERVE, 0, 0, 0, 0));
    send_word(make_word(CMD_RESERVE, 65, 0, 0, 0));
    send_word(make_word(CMD_RESERVE, 1, 0, 0, 0));
    send_word(make_word(CMD_RESERVE, 64, 0, 0, 0));
    send_word(make_word(CMD_RESERVE, 3, 0, 0, 0));
    send_word(make_word(CMD_RESERVE, 127, 0, 0, 0));
    send_word(make_word(CMD_FILL, 0, 0, 0, 8'hFF));
    send_word(make_word(CMD_FILL, 0, 0, 1, 8'h11));
    send_word(make_word(CMD_FILL, 0, 2, 0, 8'h22));
    send_word(make_word(CMD_FILL, 0, 15, 63, 8'h00));
    send_word(make_word(CMD_FILL, 0, 1, 63, 8'hA5));
    send_word(make_word(CMD_UNUSED, 127, 15, 63, 8'hFF));
    send_word(make_word(CMD_TAKE, 0, 0, 0, 0));
    send_word(make_word(CMD_FILL, 0, 0, 0, 8'h33));
    send_word(make_word(CMD_RESERVE, 2, 0, 0, 0));
    send_word(make_word(CMD_TAKE, 0, 0, 0, 0));
    send_word(make_word(CMD_FILL, 0, 0, 1, 8'h5A));

    plan = {5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd5, 5'd2, 5'd11, 5'd16};
    foreach (plan[p]) begin
      if (p == plan.size() - 1) steady_flow = 1'b1;
      write_capacity(plan[p]);
      cap_now = (plan[p] == 0) ? 1 :
                (plan[p] > MAX_SLOTS_DEFAULT) ? MAX_SLOTS_DEFAULT : plan[p];
      repeat (WORDS_PER_PHASE) begin
        w = make_word(CMD_TAKE, $urandom_range(0, 127), $urandom_range(0, 15),
                      $urandom_range(0, 63), $urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          w.command = CMD_RESERVE;
          pick = $urandom_range(0, 99);
          if (pick < 80) w.message_length = LENGTH_W'($urandom_range(1, 4));
          else if (pick < 92) w.message_length = LENGTH_W'($urandom_range(5, PREFILL_BYTES));
          else if (pick < 96) w.message_length = '0;
          else w.message_length = LENGTH_W'($urandom_range(65, 127));
        end else if (pick < 50) begin
          w.command = CMD_FILL;
          if ($urandom_range(0, 6) != 0) w.target_slot = SLOT_W'($urandom_range(0, cap_now - 1));
          if ($urandom_range(0, 4) != 0) w.byte_offset = OFFSET_W'($urandom_range(0, 3));
        end else if (pick >= 96) begin
          w.command = CMD_UNUSED;
        end
        send_word(w);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (16) @(posedge clk);
    $display("sent %0d command words over %0d capacity settings including 0, 1, 16 and 31",
             words_sent, settings_done);
    $display("compared %0d result words against the predicted ring state", results_checked);
    if (mismatch_count == 0) begin
      $display("[message_slot_ring_byte_queue] OK");
    end else begin
      $display("[message_slot_ring_byte_queue] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/msrbq_pkg.sv
src/msrbq_ram.sv
src/msrbq_ctrl.sv
src/message_slot_ring_byte_queue.sv
tb/message_slot_ring_byte_queue_checker.sv
tb/tb_message_slot_ring_byte_queue.sv
